// File: src/lkt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lkt_pkg;

  localparam int KEY_W = 64;
  localparam int CAP_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // register index as decoded from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  typedef logic [1:0] op_t;

  localparam op_t OP_ADD    = 2'd0;
  localparam op_t OP_SEARCH = 2'd1;
  localparam op_t OP_REMOVE = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic upd;
    logic emit;
  } lkt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } lkt_sts_t;

endpackage

`default_nettype wire

// File: src/lkt_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lkt_in_if;
  import lkt_pkg::*;

  logic             valid;
  logic             ready;
  op_t              operation;
  logic [KEY_W-1:0] key;

  modport source (output valid, output operation, output key, input ready);
  modport sink (input valid, input operation, input key, output ready);
endinterface

`default_nettype wire

// File: src/lkt_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lkt_out_if;
  import lkt_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic             evicted;
  logic [KEY_W-1:0] evicted_key;
  logic             was_empty;

  modport source (output valid, output found, output evicted, output evicted_key,
                  output was_empty, input ready);
  modport sink (input valid, input found, input evicted, input evicted_key,
                input was_empty, output ready);
endinterface

`default_nettype wire

// File: src/lru_key_table.sv
`timescale 1ns / 1ps
`default_nettype none
// One item at a time: a new item is taken only after the last one has been emitted.
// Each item is handled by a scan of the key RAM, one read per cycle, followed by an
// update step and an output step that holds until the output register frees up.
// Reset (synchronous, active low): table empty, capacity 16, no result pending.
// The key RAM needs no clearing; entries are qualified by their valid bits.

module lru_key_table #(
  parameter int ENTRIES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  lkt_in_if.sink                                 in_ch,
  lkt_out_if.source                              out_ch,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [lkt_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [lkt_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic      [lkt_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                   cfg_pready
);
  import lkt_pkg::*;

  logic [CAP_W-1:0] capacity_r;
  logic             in_ready;
  lkt_cmd_t         cmd;
  lkt_sts_t         sts;

  // configuration port
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_CAPACITY)) begin
      capacity_r <= cfg_pwdata[CAP_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_CAPACITY) ? CFG_DATA_W'(capacity_r) : '0;

  assign in_ch.ready = in_ready;

  lkt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lkt_datapath #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_ch.operation),
    .in_key          (in_ch.key),
    .capacity        (capacity_r),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_found       (out_ch.found),
    .out_evicted     (out_ch.evicted),
    .out_evicted_key (out_ch.evicted_key),
    .out_was_empty   (out_ch.was_empty)
  );

endmodule

`default_nettype wire

// File: src/lkt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lkt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/lkt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lkt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire lkt_pkg::lkt_sts_t sts,
  output lkt_pkg::lkt_cmd_t      cmd
);
  import lkt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the output register frees up
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/lkt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module lkt_datapath #(
  parameter int ENTRIES = 16,
  localparam int AW = $clog2(ENTRIES),
  localparam int CW = $clog2(ENTRIES + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire lkt_pkg::lkt_cmd_t          cmd,
  output lkt_pkg::lkt_sts_t               sts,
  input  wire lkt_pkg::op_t               in_operation,
  input  wire logic [lkt_pkg::KEY_W-1:0]  in_key,
  input  wire logic [lkt_pkg::CAP_W-1:0]  capacity,
  input  wire logic                       out_ready,
  output logic                            out_valid,
  output logic                            out_found,
  output logic                            out_evicted,
  output logic [lkt_pkg::KEY_W-1:0]       out_evicted_key,
  output logic                            out_was_empty
);
  import lkt_pkg::*;

  localparam int LW = (CW > CAP_W) ? CW : CAP_W;

  // item and scan results
  op_t              op_r;
  logic [KEY_W-1:0] key_r;
  logic [CW-1:0]    cnt_r;
  logic             hit_r;
  logic [AW-1:0]    hit_idx_r;
  logic [AW-1:0]    old_idx_r;
  logic [AW-1:0]    old2_idx_r;
  logic             free_ok_r;
  logic [AW-1:0]    free_idx_r;

  // table state
  logic             valid_r   [ENTRIES];
  logic             valid_nxt [ENTRIES];
  logic [AW-1:0]    age_r     [ENTRIES];
  logic [AW-1:0]    age_nxt   [ENTRIES];
  logic [CW-1:0]    live_r;
  logic [CW-1:0]    live_nxt;

  logic             res_found_r;
  logic             res_evict_r;
  logic             res_empty_r;
  logic             out_valid_r;
  logic             out_found_r;
  logic             out_evicted_r;
  logic [KEY_W-1:0] out_key_r;
  logic             out_empty_r;

  // key store
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [KEY_W-1:0] ram_rdata;

  lkt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (ENTRIES)
  ) u_keys (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (key_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // scan: read entry cnt, compare entry cnt-1 against the returned word
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] scan_idx;
  logic          cmp_en;
  logic [CW-1:0] live_m1;
  logic [CW-1:0] live_m2;

  assign cnt_m1   = cnt_r - CW'(1);
  assign scan_idx = cnt_m1[AW-1:0];
  assign cmp_en   = cmd.scan && (cnt_r != '0);
  assign live_m1  = live_r - CW'(1);
  assign live_m2  = live_r - CW'(2);

  assign sts.scan_done = cmd.scan && (cnt_r == CW'(ENTRIES));
  assign sts.out_busy  = out_valid_r && !out_ready;

  // effective capacity, clamped to 1..ENTRIES
  logic [LW-1:0] cap_ext;
  logic [LW-1:0] cap_eff;
  logic [LW-1:0] live_ext;

  assign cap_ext  = LW'(capacity);
  assign live_ext = LW'(live_r);

  always_comb begin
    if (capacity == '0) begin
      cap_eff = LW'(1);
    end else if (cap_ext > LW'(ENTRIES)) begin
      cap_eff = LW'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  // update decisions
  logic          is_add;
  logic          is_search;
  logic          is_remove;
  logic [AW-1:0] hit_age;
  logic          drop;
  logic [AW-1:0] drop_idx;
  logic          ins;
  logic [AW-1:0] ins_idx;

  assign is_add    = (op_r == OP_ADD);
  assign is_search = (op_r == OP_SEARCH);
  assign is_remove = (op_r == OP_REMOVE);
  assign hit_age   = age_r[hit_idx_r];

  always_comb begin
    drop     = 1'b0;
    drop_idx = old_idx_r;
    ins      = 1'b0;
    if (is_add && hit_r) begin
      drop = (live_ext > cap_eff);
      // the refreshed entry was the oldest: the next one in line takes its place
      if (hit_age == live_m1[AW-1:0]) begin
        drop_idx = (live_r == CW'(1)) ? hit_idx_r : old2_idx_r;
      end
    end else if (is_add) begin
      drop = (live_ext >= cap_eff);
      ins  = 1'b1;
    end else if (is_remove) begin
      drop = (live_r != '0);
    end
    // reuse the freed slot when there is no free one or it comes before the first free one
    if (drop && (!free_ok_r || (old_idx_r < free_idx_r))) begin
      ins_idx = old_idx_r;
    end else begin
      ins_idx = free_idx_r;
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      valid_nxt[i] = valid_r[i];
      age_nxt[i]   = age_r[i];
      if (is_add && hit_r) begin
        if (valid_r[i] && (age_r[i] < hit_age)) begin
          age_nxt[i] = age_r[i] + AW'(1);
        end
        if (AW'(i) == hit_idx_r) begin
          age_nxt[i] = '0;
        end
      end else if (is_add) begin
        if (valid_r[i]) begin
          age_nxt[i] = age_r[i] + AW'(1);
        end
      end
      if (drop && (AW'(i) == drop_idx)) begin
        valid_nxt[i] = 1'b0;
        age_nxt[i]   = '0;
      end
      if (ins && (AW'(i) == ins_idx)) begin
        valid_nxt[i] = 1'b1;
        age_nxt[i]   = '0;
      end
    end
    live_nxt = live_r - CW'(drop) + CW'(ins);
  end

  always_comb begin
    ram_we    = cmd.upd && ins;
    ram_waddr = ins_idx;
    if (cmd.upd) begin
      ram_re    = drop;
      ram_raddr = drop_idx;
    end else begin
      ram_re    = cmd.scan && (cnt_r < CW'(ENTRIES));
      ram_raddr = cnt_r[AW-1:0];
    end
  end

  // item capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      hit_r     <= 1'b0;
      free_ok_r <= 1'b0;
    end else if (cmd.load) begin
      cnt_r     <= '0;
      hit_r     <= 1'b0;
      free_ok_r <= 1'b0;
    end else if (cmd.scan) begin
      cnt_r <= cnt_r + CW'(1);
      if (cmp_en) begin
        if (valid_r[scan_idx] && (ram_rdata == key_r)) begin
          hit_r <= 1'b1;
        end
        if (!valid_r[scan_idx] && !free_ok_r) begin
          free_ok_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      key_r <= in_key;
    end
    if (cmp_en) begin
      if (valid_r[scan_idx] && (ram_rdata == key_r)) begin
        hit_idx_r <= scan_idx;
      end
      if (valid_r[scan_idx] && (age_r[scan_idx] == live_m1[AW-1:0])) begin
        old_idx_r <= scan_idx;
      end
      if (valid_r[scan_idx] && (age_r[scan_idx] == live_m2[AW-1:0])) begin
        old2_idx_r <= scan_idx;
      end
      if (!valid_r[scan_idx] && !free_ok_r) begin
        free_idx_r <= scan_idx;
      end
    end
    if (cmd.upd) begin
      res_found_r <= (is_add || is_search) && hit_r;
      res_evict_r <= drop;
      res_empty_r <= is_remove && (live_r == '0);
    end
    if (cmd.emit) begin
      out_found_r   <= res_found_r;
      out_evicted_r <= res_evict_r;
      out_key_r     <= res_evict_r ? ram_rdata : '0;
      out_empty_r   <= res_empty_r;
    end
  end

  // table state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
        age_r[i]   <= '0;
      end
      live_r <= '0;
    end else if (cmd.upd) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid_r[i] <= valid_nxt[i];
        age_r[i]   <= age_nxt[i];
      end
      live_r <= live_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_key_r;
  assign out_was_empty   = out_empty_r;

endmodule

`default_nettype wire

// File: tb/tb_lru_key_table.sv
`timescale 1ns / 1ps

module tb_lru_key_table;
  import lkt_pkg::*;

  localparam int ENTRIES     = 16;
  localparam int KEY_POOL    = 24;
  localparam int SEGMENTS    = 9;
  localparam int SEG_ITEMS   = 70;
  localparam int QUIET_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;

  // not decoded by the block; must leave the table untouched
  localparam op_t OP_UNUSED = 2'd3;

  typedef struct packed {
    logic             found;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
    logic             was_empty;
  } reply_t;

  // Shadow of the table: predicts one reply per accepted item and checks the replies.
  class lru_shadow;
    logic [KEY_W-1:0] keys[ENTRIES];
    bit               used[ENTRIES];
    int               rank[ENTRIES];
    int               live;
    logic [CAP_W-1:0] capacity;
    reply_t           pending[$];
    int               errors;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        keys[i] = '0;
        used[i] = 1'b0;
        rank[i] = 0;
      end
      live = 0;
      capacity = CAP_RESET;
      errors = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      capacity = value;
    endfunction

    function int limit();
      int c;
      c = capacity;
      if (c == 0) c = 1;
      if (c > ENTRIES) c = ENTRIES;
      return c;
    endfunction

    function int locate(logic [KEY_W-1:0] key);
      for (int i = 0; i < ENTRIES; i++)
        if (used[i] && keys[i] == key) return i;
      return -1;
    endfunction

    function bit drop_lru(output logic [KEY_W-1:0] victim);
      victim = '0;
      if (live == 0) return 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (used[i] && rank[i] == live - 1) begin
          victim = keys[i];
          used[i] = 1'b0;
          rank[i] = 0;
          live--;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void take_op(op_t op, logic [KEY_W-1:0] key);
      reply_t           r;
      int               slot;
      int               lim;
      int               a;
      logic [KEY_W-1:0] victim;
      r = '0;
      slot = locate(key);
      lim = limit();
      case (op)
        OP_ADD: begin
          if (slot >= 0) begin
            r.found = 1'b1;
            a = rank[slot];
            for (int i = 0; i < ENTRIES; i++)
              if (used[i] && rank[i] < a) rank[i]++;
            rank[slot] = 0;
            // a refresh still trims one entry when capacity was lowered
            if (live > lim && drop_lru(victim)) begin
              r.evicted = 1'b1;
              r.evicted_key = victim;
            end
          end else begin
            if (live + 1 > lim && drop_lru(victim)) begin
              r.evicted = 1'b1;
              r.evicted_key = victim;
            end
            for (int i = 0; i < ENTRIES; i++)
              if (used[i]) rank[i]++;
            for (int i = 0; i < ENTRIES; i++) begin
              if (!used[i]) begin
                used[i] = 1'b1;
                keys[i] = key;
                rank[i] = 0;
                live++;
                break;
              end
            end
          end
        end
        OP_SEARCH: r.found = (slot >= 0);
        OP_REMOVE: begin
          if (drop_lru(victim)) begin
            r.evicted = 1'b1;
            r.evicted_key = victim;
          end else begin
            r.was_empty = 1'b1;
          end
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_reply(logic found, logic evicted, logic [KEY_W-1:0] evicted_key,
                              logic was_empty);
      reply_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with no item pending: found=%b evicted=%b key=%h empty=%b",
                   $realtime, found, evicted, evicted_key, was_empty);
        return;
      end
      want = pending.pop_front();
      if (found !== want.found || evicted !== want.evicted ||
          evicted_key !== want.evicted_key || was_empty !== want.was_empty) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: mismatch: want found=%b evicted=%b key=%h empty=%b, got %b %b %h %b",
                   $realtime, want.found, want.evicted, want.evicted_key, want.was_empty,
                   found, evicted, evicted_key, was_empty);
      end
    endfunction

    function void close();
      if (pending.size() != 0) begin
        errors += pending.size();
        $display("%0t: %0d results never arrived", $realtime, pending.size());
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  lkt_in_if  in_if();
  lkt_out_if out_if();

  lru_key_table #(.ENTRIES(ENTRIES)) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if.sink),
    .out_ch      (out_if.source),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  lru_shadow        sb;
  int               send_idle;
  int               recv_idle;
  int               quiet_cycles;
  logic [KEY_W-1:0] key_pool[KEY_POOL];

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_if.ready = ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_reply(out_if.found, out_if.evicted, out_if.evicted_key, out_if.was_empty);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("tb_lru_key_table: errors");
          $finish;
        end
      end
    end
  end

  // Called just after a falling edge; returns just after the falling edge past acceptance.
  task automatic send_item(op_t op, logic [KEY_W-1:0] key);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.operation = op;
    in_if.key = key;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.take_op(op, key);
    @(negedge clk);
  endtask

  task automatic send_random();
    int               pick;
    op_t              op;
    logic [KEY_W-1:0] key;
    pick = $urandom_range(99);
    if (pick < 50) op = OP_ADD;
    else if (pick < 75) op = OP_SEARCH;
    else if (pick < 93) op = OP_REMOVE;
    else op = OP_UNUSED;
    // mostly reuse keys so hits, refreshes and evictions are frequent
    if ($urandom_range(99) < 80) key = key_pool[$urandom_range(KEY_POOL - 1)];
    else key = {$urandom, $urandom};
    send_item(op, key);
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {REG_CAPACITY, 2'b00};
    cfg_pwdata = CFG_DATA_W'(value);
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_capacity(value);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  initial begin
    int seg_caps[SEGMENTS];
    seg_caps = '{3, 1, 16, 0, 31, 5, 2, 17, 8};
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    send_idle = 0;
    recv_idle = 0;
    quiet_cycles = 0;
    in_if.valid = 1'b0;
    in_if.operation = OP_ADD;
    in_if.key = '0;
    out_if.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};

    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // empty table, extreme keys, refresh, fill past capacity 16, unused code
    send_item(OP_REMOVE, '0);
    send_item(OP_SEARCH, '0);
    send_item(OP_ADD, '0);
    send_item(OP_ADD, '1);
    send_item(OP_SEARCH, '0);
    send_item(OP_ADD, '0);
    for (int i = 2; i < 17; i++) send_item(OP_ADD, key_pool[i]);
    send_item(OP_SEARCH, '1);
    send_item(OP_UNUSED, '1);
    send_item(OP_REMOVE, '1);
    in_if.valid = 1'b0;

    for (int s = 0; s < SEGMENTS; s++) begin
      wait_drained();
      // first segment lowers capacity below the live count left by the fill above
      write_capacity(CAP_W'(seg_caps[s]));
      send_idle = (s < 3) ? 36 : (s < 6) ? 87 : 0;
      recv_idle = (s < 3) ? 87 : (s < 6) ? 36 : 0;
      for (int j = 0; j < 4; j++)
        key_pool[$urandom_range(KEY_POOL - 1, 2)] = {$urandom, $urandom};
      repeat (SEG_ITEMS) send_random();
      in_if.valid = 1'b0;
    end

    wait_drained();
    repeat (ENTRIES + 8) @(negedge clk);
    sb.close();
    if (sb.errors == 0) begin
      $display("tb_lru_key_table: clean");
    end else begin
      $display("tb_lru_key_table: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
src/lkt_pkg.sv
src/lkt_in_if.sv
src/lkt_out_if.sv
src/lkt_ram.sv
src/lkt_ctrl.sv
src/lkt_datapath.sv
src/lru_key_table.sv
tb/tb_lru_key_table.sv
